### design/led_blink_pattern_sequencer_top_assert.svh
// ----------------------------------------------------------------------------
// led blink pattern sequencer assertion macros
// concurrent checks, compiled out for synthesis
// ----------------------------------------------------------------------------
`ifndef LED_BLINK_PATTERN_SEQUENCER_TOP_ASSERT_SVH
`define LED_BLINK_PATTERN_SEQUENCER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define LBPS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define LBPS_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define LBPS_ASSERT(lbl, prop, msg)
`define LBPS_NEVER(lbl, cond, msg)
`endif
`endif

### design/lbps_pkg.sv
// ----------------------------------------------------------------------------
// lbps_pkg
// shared types, codes and constants of the led blink pattern sequencer
// ----------------------------------------------------------------------------
package lbps_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int MAX_SYMBOLS_DEF = 16;
    localparam int LED_COUNT_DEF   = 8;

    localparam logic [15:0] SHORT_TICKS_RST = 16'd100;
    localparam logic [15:0] LONG_TICKS_RST  = 16'd250;

    localparam logic [31:0] ERR_SYMBOLS = 32'h0001_1111;
    localparam logic [4:0]  ERR_LENGTH  = 5'd9;
    localparam logic [23:0] ERR_COLOUR  = 24'h80_0000;

    localparam logic [7:0] CFG_SHORT_TICKS = 8'd0;
    localparam logic [7:0] CFG_LONG_TICKS  = 8'd1;

    typedef enum logic [1:0] {
        REQ_JOB   = 2'd0,
        REQ_ERROR = 2'd1,
        REQ_TICK  = 2'd2
    } req_type_t;

    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_ACK   = 1'b1;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [2:0]  led_slot;
        logic [31:0] symbols;
        logic [4:0]  symbol_count;
        logic [7:0]  red_in;
        logic [7:0]  green_in;
        logic [7:0]  blue_in;
    } in_item_t;

    typedef struct packed {
        logic        result_kind;
        logic        accepted;
        logic [2:0]  pixel_position;
        logic [7:0]  red_out;
        logic [7:0]  green_out;
        logic [7:0]  blue_out;
        logic        last;
    } out_item_t;

    typedef struct packed {
        logic [2:0]  led;
        logic [31:0] symbols;
        logic [5:0]  length;
        logic [23:0] colour;
        logic [5:0]  position;
        logic [31:0] deadline;
    } job_t;

    typedef struct packed {
        logic wr;
        logic upd;
        logic rem;
    } queue_op_t;

    function automatic logic [2:0] slot_to_pos(input logic [2:0] slot);
        logic [2:0] pos;
        case (slot)
            3'd0:    pos = 3'd7;
            3'd1:    pos = 3'd0;
            3'd2:    pos = 3'd6;
            3'd3:    pos = 3'd1;
            3'd4:    pos = 3'd5;
            3'd5:    pos = 3'd2;
            3'd6:    pos = 3'd4;
            default: pos = 3'd3;
        endcase
        return pos;
    endfunction

endpackage

### design/lbps_queue.sv
// ----------------------------------------------------------------------------
// lbps_queue
// job storage kept packed in arrival order, closing the gap on removal by a shift
// ----------------------------------------------------------------------------
module lbps_queue #(
    parameter int QUEUE_DEPTH = lbps_pkg::QUEUE_DEPTH_DEF,
    parameter int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1
) (
    input  logic                clk,
    input  lbps_pkg::queue_op_t op,
    input  logic [IW-1:0]       idx,
    input  lbps_pkg::job_t      wr_job,
    input  logic [5:0]          upd_position,
    input  logic [31:0]         upd_deadline,
    output lbps_pkg::job_t      rd_job
);
    import lbps_pkg::*;

    job_t q_reg [QUEUE_DEPTH];

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < QUEUE_DEPTH; k++)
        begin
            if (op.rem && (IW'(k) >= idx) && (k < QUEUE_DEPTH - 1))
            begin
                q_reg[k] <= q_reg[k + 1];
            end
            else if (op.wr && (IW'(k) == idx))
            begin
                q_reg[k] <= wr_job;
            end
            else if (op.upd && (IW'(k) == idx))
            begin
                q_reg[k].position <= upd_position;
                q_reg[k].deadline <= upd_deadline;
            end
        end
    end

    assign rd_job = q_reg[idx];

endmodule

### design/led_blink_pattern_sequencer_top.sv
// ----------------------------------------------------------------------------
// led_blink_pattern_sequencer_top
// blink job queue and millisecond tick sequencer
// ----------------------------------------------------------------------------
// An enqueue returns its acknowledgement in the cycle after the request.
// A tick keeps busy high while the sequencer walks the queue one job a
// cycle through a single deadline compare and deadline adder. Results come
// as single-cycle result_strobe pulses and cannot be stalled; the last one
// of a tick carries last for strip show.
module led_blink_pattern_sequencer_top #(
    parameter int QUEUE_DEPTH = lbps_pkg::QUEUE_DEPTH_DEF,
    parameter int MAX_SYMBOLS = lbps_pkg::MAX_SYMBOLS_DEF,
    parameter int LED_COUNT   = lbps_pkg::LED_COUNT_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  lbps_pkg::in_item_t  req,
    output logic                result_strobe,
    output lbps_pkg::out_item_t result,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [7:0]          cfg_index,
    input  logic [15:0]         cfg_data
);
    import lbps_pkg::*;

`include "led_blink_pattern_sequencer_top_assert.svh"

    localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_WALK = 2'b10
    } state_t;

    state_t           state_reg, state_next;
    logic [15:0]      short_reg, long_reg;
    logic [31:0]      now_reg, now_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [CW-1:0]    i_reg, i_next;
    logic [LED_COUNT-1:0] used_reg, used_next;
    logic             pend_valid_reg, pend_valid_next;
    out_item_t        pend_reg, pend_next;
    logic             strobe_reg, strobe_next;
    out_item_t        out_reg, out_next;

    queue_op_t        op;
    logic [IW-1:0]    q_idx;
    job_t             wr_job, rd_job;
    logic [5:0]       upd_position;
    logic [31:0]      upd_deadline;

    logic [5:0]       sat_len;
    logic [4:0]       raw_len;
    logic [6:0]       p;
    logic             ends;
    logic [1:0]       code;
    logic [15:0]      dur;
    out_item_t        step_item;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            short_reg <= SHORT_TICKS_RST;
            long_reg  <= LONG_TICKS_RST;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == CFG_SHORT_TICKS)
            begin
                short_reg <= cfg_data;
            end
            else if (cfg_index == CFG_LONG_TICKS)
            begin
                long_reg <= cfg_data;
            end
        end
    end

    // enqueue data
    always_comb
    begin
        raw_len = (req.req_type == REQ_ERROR) ? ERR_LENGTH : req.symbol_count;
        sat_len = ({1'b0, raw_len} > 6'(MAX_SYMBOLS)) ? 6'(MAX_SYMBOLS) : {1'b0, raw_len};
        wr_job.led      = slot_to_pos(req.led_slot);
        wr_job.symbols  = (req.req_type == REQ_ERROR) ? ERR_SYMBOLS : req.symbols;
        wr_job.length   = sat_len;
        wr_job.colour   = (req.req_type == REQ_ERROR) ? ERR_COLOUR
                          : {req.red_in, req.green_in, req.blue_in};
        wr_job.position = 6'd0;
        wr_job.deadline = 32'd0;
    end

    // per-job step: symbol index is the old position
    always_comb
    begin
        p    = {1'b0, rd_job.position} + 7'd1;
        ends = p > {1'b0, rd_job.length};
        code = (rd_job.position < 6'd16) ? 2'(rd_job.symbols >> {rd_job.position, 1'b0})
                                         : 2'd0;
        dur  = code[1] ? long_reg : short_reg;
        upd_position = p[5:0];
        upd_deadline = now_reg + {16'd0, dur};
        step_item.result_kind    = KIND_PIXEL;
        step_item.accepted       = 1'b0;
        step_item.pixel_position = rd_job.led;
        {step_item.red_out, step_item.green_out, step_item.blue_out} =
            (!ends && code[0]) ? rd_job.colour : 24'd0;
        step_item.last           = 1'b0;
    end

    always_comb
    begin
        state_next      = state_reg;
        now_next        = now_reg;
        count_next      = count_reg;
        i_next          = i_reg;
        used_next       = used_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        strobe_next     = 1'b0;
        out_next        = out_reg;
        op              = '0;
        q_idx           = i_reg[IW-1:0];
        case (state_reg)
            ST_IDLE:
            begin
                q_idx = count_reg[IW-1:0];
                if (start)
                begin
                    case (req.req_type)
                        REQ_JOB, REQ_ERROR:
                        begin
                            strobe_next = 1'b1;
                            out_next = '0;
                            out_next.result_kind = KIND_ACK;
                            out_next.last = 1'b1;
                            if (count_reg < CW'(QUEUE_DEPTH))
                            begin
                                op.wr = 1'b1;
                                out_next.accepted = 1'b1;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        REQ_TICK:
                        begin
                            now_next        = now_reg + 32'd1;
                            i_next          = '0;
                            used_next       = '0;
                            pend_valid_next = 1'b0;
                            state_next      = ST_WALK;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_WALK:
            begin
                if (i_reg >= count_reg)
                begin
                    if (pend_valid_reg)
                    begin
                        strobe_next   = 1'b1;
                        out_next      = pend_reg;
                        out_next.last = 1'b1;
                    end
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
                else if (used_reg[rd_job.led])
                begin
                    i_next = i_reg + CW'(1);
                end
                else
                begin
                    used_next[rd_job.led] = 1'b1;
                    if (rd_job.deadline < now_reg)
                    begin
                        // hold one result back so the final one can carry last
                        if (pend_valid_reg)
                        begin
                            strobe_next = 1'b1;
                            out_next    = pend_reg;
                        end
                        pend_valid_next = 1'b1;
                        pend_next       = step_item;
                        if (ends)
                        begin
                            op.rem     = 1'b1;
                            count_next = count_reg - CW'(1);
                        end
                        else
                        begin
                            op.upd = 1'b1;
                            i_next = i_reg + CW'(1);
                        end
                    end
                    else
                    begin
                        i_next = i_reg + CW'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            now_reg        <= '0;
            count_reg      <= '0;
            i_reg          <= '0;
            used_reg       <= '0;
            pend_valid_reg <= 1'b0;
            strobe_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            now_reg        <= now_next;
            count_reg      <= count_next;
            i_reg          <= i_next;
            used_reg       <= used_next;
            pend_valid_reg <= pend_valid_next;
            strobe_reg     <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

    lbps_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .IW          (IW)
    ) u_queue (
        .clk          (clk),
        .op           (op),
        .idx          (q_idx),
        .wr_job       (wr_job),
        .upd_position (upd_position),
        .upd_deadline (upd_deadline),
        .rd_job       (rd_job)
    );

    assign busy          = (state_reg == ST_WALK);
    assign result_strobe = strobe_reg;
    assign result        = out_reg;

    `LBPS_NEVER(a_count_bound, count_reg > CW'(QUEUE_DEPTH), "job count beyond queue depth")
    `LBPS_ASSERT(a_pend_in_walk, pend_valid_reg |-> state_reg == ST_WALK, "held result outside walk")
    `LBPS_ASSERT(a_ack_last, strobe_reg && out_reg.result_kind |-> out_reg.last, "ack without last")
    `LBPS_ASSERT(a_walk_end, state_reg == ST_WALK && i_reg >= count_reg |=> state_reg == ST_IDLE, "walk did not end")

endmodule

### dv/led_blink_pattern_sequencer_checker.sv
// ----------------------------------------------------------------------------
// led_blink_pattern_sequencer_checker
// watches the request, result and config channels of the sequencer, keeps
// its own copy of the job queue and compares every result in order
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module led_blink_pattern_sequencer_checker
    import lbps_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  in_item_t    req,
    input  logic        result_strobe,
    input  out_item_t   result,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output int          fail_count,
    output int          pending,
    output int          items_seen,
    output int          results_seen
);

    localparam int DEPTH = QUEUE_DEPTH_DEF;

    typedef struct {
        logic        valid;
        logic [2:0]  led;
        logic [31:0] syms;
        logic [4:0]  len;
        logic [23:0] colour;
        logic [4:0]  pos;
        logic [31:0] deadline;
    } blink_job_t;

    blink_job_t  jobs [DEPTH];
    logic [15:0] short_len;
    logic [15:0] long_len;
    logic [31:0] now_ms;
    out_item_t   pixel_queue [$];

    function automatic out_item_t make_item(logic kind, logic acc, logic [2:0] pos,
                                            logic [23:0] colour);
        out_item_t r;
        r.result_kind    = kind;
        r.accepted       = acc;
        r.pixel_position = pos;
        r.red_out        = colour[23:16];
        r.green_out      = colour[15:8];
        r.blue_out       = colour[7:0];
        r.last           = 1'b0;
        return r;
    endfunction

    task automatic store_job(logic [2:0] led, logic [31:0] syms, logic [4:0] len,
                             logic [23:0] colour);
        int        slot;
        out_item_t ack;
        slot = -1;
        for (int i = DEPTH - 1; i >= 0; i--)
            if (!jobs[i].valid)
                slot = i;
        ack = make_item(KIND_ACK, slot >= 0, 3'd0, 24'd0);
        ack.last = 1'b1;
        if (slot >= 0)
        begin
            jobs[slot].valid    = 1'b1;
            jobs[slot].led      = led;
            jobs[slot].syms     = syms;
            jobs[slot].len      = (len > MAX_SYMBOLS_DEF) ? 5'(MAX_SYMBOLS_DEF) : len;
            jobs[slot].colour   = colour;
            jobs[slot].pos      = 5'd0;
            jobs[slot].deadline = 32'd0;
        end
        pixel_queue = {pixel_queue, ack};
    endtask

    task automatic advance_tick();
        logic [7:0]  used;
        logic [5:0]  p;
        logic [1:0]  code;
        logic [31:0] dur;
        int          i;
        int          n;
        used   = 8'd0;
        i      = 0;
        n      = 0;
        now_ms = now_ms + 32'd1;
        while (i < DEPTH && jobs[i].valid)
        begin
            if (used[jobs[i].led])
            begin
                i++;
            end
            else
            begin
                used[jobs[i].led] = 1'b1;
                if (jobs[i].deadline < now_ms)
                begin
                    p = jobs[i].pos + 6'd1;
                    if (p > jobs[i].len)
                    begin
                        // job done: write black, close the gap behind it
                        pixel_queue = {pixel_queue,
                                       make_item(KIND_PIXEL, 1'b0, jobs[i].led, 24'd0)};
                        n++;
                        for (int k = i; k + 1 < DEPTH; k++)
                            jobs[k] = jobs[k + 1];
                        jobs[DEPTH - 1].valid = 1'b0;
                    end
                    else
                    begin
                        code = (p - 6'd1 < 6'd16) ? 2'(jobs[i].syms >> (2 * (p - 6'd1))) : 2'd0;
                        dur  = code[1] ? 32'(long_len) : 32'(short_len);
                        pixel_queue = {pixel_queue,
                                       make_item(KIND_PIXEL, 1'b0, jobs[i].led,
                                                 code[0] ? jobs[i].colour : 24'd0)};
                        n++;
                        jobs[i].pos      = p[4:0];
                        jobs[i].deadline = now_ms + dur;
                        i++;
                    end
                end
                else
                begin
                    i++;
                end
            end
        end
        if (n > 0)
            pixel_queue[pixel_queue.size() - 1].last = 1'b1;
    endtask

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        $display("%0t mismatch on %s: got %0h, expected %0h", $realtime, field, got, want);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        if (!rst_n)
        begin
            short_len    = SHORT_TICKS_RST;
            long_len     = LONG_TICKS_RST;
            now_ms       = 32'd0;
            for (int i = 0; i < DEPTH; i++)
                jobs[i].valid = 1'b0;
            pixel_queue.delete();
            fail_count   = 0;
            items_seen   = 0;
            results_seen = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_SHORT_TICKS)
                    short_len = cfg_data;
                else if (cfg_index == CFG_LONG_TICKS)
                    long_len = cfg_data;
            end
            if (start && !busy)
            begin
                items_seen++;
                case (req.req_type)
                    REQ_JOB:   store_job(slot_to_pos(req.led_slot), req.symbols,
                                         req.symbol_count,
                                         {req.red_in, req.green_in, req.blue_in});
                    REQ_ERROR: store_job(slot_to_pos(req.led_slot), ERR_SYMBOLS,
                                         ERR_LENGTH, ERR_COLOUR);
                    REQ_TICK:  advance_tick();
                    default:   ;
                endcase
            end
            if (result_strobe)
            begin
                results_seen++;
                if (pixel_queue.size() == 0)
                begin
                    report_mismatch("result_strobe", 32'd1, 32'd0);
                end
                else
                begin
                    want = pixel_queue.pop_front();
                    if (result.result_kind !== want.result_kind)
                        report_mismatch("result_kind", result.result_kind, want.result_kind);
                    if (result.accepted !== want.accepted)
                        report_mismatch("accepted", result.accepted, want.accepted);
                    if (result.pixel_position !== want.pixel_position)
                        report_mismatch("pixel_position", result.pixel_position,
                                        want.pixel_position);
                    if (result.red_out !== want.red_out)
                        report_mismatch("red_out", result.red_out, want.red_out);
                    if (result.green_out !== want.green_out)
                        report_mismatch("green_out", result.green_out, want.green_out);
                    if (result.blue_out !== want.blue_out)
                        report_mismatch("blue_out", result.blue_out, want.blue_out);
                    if (result.last !== want.last)
                        report_mismatch("last", result.last, want.last);
                end
            end
        end
        pending = pixel_queue.size();
    end

endmodule

### dv/led_blink_pattern_sequencer_top_tb.sv
// ----------------------------------------------------------------------------
// led_blink_pattern_sequencer_top_tb
// drives blink jobs, error blinks and ticks with random gaps across several
// timing settings; the checker predicts and compares every result
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module led_blink_pattern_sequencer_top_tb;
    import lbps_pkg::*;

    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam int         IDLE_LIMIT = 5000;
    localparam int         SETTLE     = QUEUE_DEPTH_DEF + 8;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    in_item_t    req;
    logic        result_strobe;
    out_item_t   result;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  cfg_index;
    logic [15:0] cfg_data;
    int          fail_count;
    int          pending;
    int          items_seen;
    int          results_seen;
    int          idle_cycles;

    led_blink_pattern_sequencer_top dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .req(req),
        .result_strobe(result_strobe), .result(result),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    led_blink_pattern_sequencer_checker checker_i (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .req(req),
        .result_strobe(result_strobe), .result(result),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending(pending),
        .items_seen(items_seen), .results_seen(results_seen)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || result_strobe || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic send_request(in_item_t item);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 18);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req   <= item;
        start <= 1'b1;
        do @(posedge clk); while (busy);
    endtask

    task automatic drain_results();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0 || busy)
            @(posedge clk);
    endtask

    task automatic write_timing(logic [15:0] short_val, logic [15:0] long_val);
        drain_results();
        // settle further after the drain before writing the timing registers
        repeat (SETTLE) @(posedge clk);
        for (int r = 0; r < 2; r++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= (r == 0) ? CFG_SHORT_TICKS : CFG_LONG_TICKS;
            cfg_data  <= (r == 0) ? short_val : long_val;
            do @(posedge clk); while (!cfg_ready);
            cfg_valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    function automatic in_item_t pattern_job(logic [2:0] slot, logic [31:0] syms,
                                             logic [4:0] count, logic [23:0] colour);
        in_item_t it;
        it.req_type     = REQ_JOB;
        it.led_slot     = slot;
        it.symbols      = syms;
        it.symbol_count = count;
        {it.red_in, it.green_in, it.blue_in} = colour;
        return it;
    endfunction

    function automatic in_item_t random_request();
        in_item_t it;
        int       roll;
        roll = $urandom_range(0, 99);
        it   = pattern_job(3'($urandom), $urandom,
                           ($urandom_range(0, 9) == 0) ? 5'($urandom)
                                                       : 5'($urandom_range(0, 6)),
                           24'($urandom));
        if (roll < 58)
            it.req_type = REQ_TICK;
        else if (roll < 66)
            it.req_type = REQ_ERROR;
        else if (roll < 69)
            it.req_type = REQ_UNUSED;
        return it;
    endfunction

    initial
    begin
        in_item_t it;
        rst_n     = 1'b0;
        start     = 1'b0;
        req       = '0;
        cfg_valid = 1'b0;
        cfg_index = 8'd0;
        cfg_data  = 16'd0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_timing(16'd1, 16'd3);

        // directed: extremes, empty and oversize patterns, error, unused type
        send_request(pattern_job(3'd0, 32'd0, 5'd0, 24'h000000));
        send_request(pattern_job(3'd7, 32'hFFFF_FFFF, 5'd16, 24'hFFFFFF));
        send_request(pattern_job(3'd5, 32'hA5A5_5A5A, 5'd31, 24'h12_34_56));
        it = pattern_job(3'd3, 32'd0, 5'd0, 24'd0);
        it.req_type = REQ_ERROR;
        send_request(it);
        it.req_type = REQ_UNUSED;
        send_request(it);
        // fill the queue past its depth
        for (int k = 0; k < 13; k++)
            send_request(pattern_job(3'(k), 32'h5555_5555 ^ 32'(k), 5'd2, 24'(k * 97)));
        it.req_type = REQ_TICK;
        repeat (6) send_request(it);

        for (int phase = 0; phase < 4; phase++)
        begin
            write_timing(16'($urandom_range(0, 4)), 16'($urandom_range(0, 12)));
            for (int n = 0; n < 60; n++)
            begin
                send_request(random_request());
                if (n == 30)
                    drain_results();
            end
        end

        // timing extremes
        write_timing(16'd0, 16'd0);
        repeat (20) send_request(random_request());
        write_timing(16'hFFFF, 16'hFFFF);
        repeat (15) send_request(random_request());

        drain_results();
        repeat (SETTLE) @(posedge clk);
        $display("covered %0d requests and %0d results over seven timing settings",
                 items_seen, results_seen);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

### led_blink_pattern_sequencer_top.f
+incdir+design
design/lbps_pkg.sv
design/lbps_queue.sv
design/led_blink_pattern_sequencer_top.sv
dv/led_blink_pattern_sequencer_checker.sv
dv/led_blink_pattern_sequencer_top_tb.sv
